>>> hdl/sha1h_pkg.sv
package sha1h_pkg;

   // request queue between the front and the back part (depth is a power of two)
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // digest layout
   localparam int DigestWords = 5;
   localparam logic [2:0] LAST_WORD_INDEX = 3'(DigestWords - 1);

   // compression schedule
   localparam logic [6:0] LAST_ROUND = 7'd79;

   typedef logic [31:0] word_type;
   typedef logic [1:0]  cmd_type;

   // request command codes
   localparam cmd_type CMD_ABSORB  = 2'd0;
   localparam cmd_type CMD_FINISH  = 2'd1;
   localparam cmd_type CMD_RESTART = 2'd2;

   // round constants
   localparam word_type K_ROUND0 = 32'h5a827999;
   localparam word_type K_ROUND1 = 32'h6ed9eba1;
   localparam word_type K_ROUND2 = 32'h8f1bbcdc;
   localparam word_type K_ROUND3 = 32'hca62c1d6;

   // initial chaining value
   localparam word_type INIT_VEC [DigestWords] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   // padding marker byte
   localparam logic [7:0] PAD_MARKER = 8'h80;

   // head of the request queue as seen by the back part
   typedef struct packed {
      logic       valid;
      cmd_type    cmd;
      logic [7:0] data;
   } queue_item_type;

endpackage

>>> hdl/sha1_byte_stream_hasher_top.sv
// SHA-1 hasher fed one byte per request.
// Request channel (req_valid/req_ready): req_cmd absorb takes req_data_byte,
// finish pads the message and returns the digest, restart drops the running
// hash; command code 3 is taken and ignored. Requests enter a four-deep queue,
// so req_ready stays high until that queue is full.
// Response channel (rsp_valid/rsp_ready): a finish yields five responses,
// rsp_word_index 0 to 4, most significant digest word first, rsp_last_word
// high on the fifth. The hash then starts over from the initial vector.
// Timing: every 64th absorbed byte adds the compression, 80 rounds at one
// round per cycle followed by a fold step. A finish writes the padding one
// byte a cycle, runs one or two compressions, then offers one digest word
// per cycle while the receiver is ready. During a compression the back end
// takes no bytes; requests wait in the queue.
// A stalled receiver holds the current word in the output register and the
// back end waits; requests keep filling the queue until it is full.
// Reset (synchronous, active high) empties the queue, drops any pending
// response and restores the initial chaining value and a zero byte count.
module sha1_byte_stream_hasher_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha1h_pkg::cmd_type  req_cmd,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);
   import sha1h_pkg::*;

   queue_item_type head;
   logic           pop;

   // front: accept and classify requests into the queue
   sha1h_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .head          (head),
      .pop           (pop)
   );

   // back: buffer, padding, compression and digest output
   sha1h_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

>>> hdl/sha1h_front.sv
module sha1h_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sha1h_pkg::cmd_type       req_cmd,
   input  logic [7:0]               req_data_byte,
   output sha1h_pkg::queue_item_type head,
   input  logic                     pop
);
   import sha1h_pkg::*;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
   } entry_type;

   localparam logic [QueuePtrW:0] FULL_COUNT = (QueuePtrW + 1)'(QueueDepth);

   entry_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;
   logic                   known_cmd;
   logic                   push;
   logic                   do_pop;

   // classify: unused command codes are taken and dropped
   assign known_cmd = (req_cmd == CMD_ABSORB) || (req_cmd == CMD_FINISH) ||
                      (req_cmd == CMD_RESTART);
   assign req_ready = (count_ff != FULL_COUNT);
   assign push      = req_valid && req_ready && known_cmd;
   assign do_pop    = pop && (count_ff != '0);

   // queue head
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff].cmd;
   assign head.data  = entry_ff[rd_ptr_ff].data;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cmd: req_cmd, data: req_data_byte};
      end
   end

endmodule

>>> hdl/sha1h_back.sv
module sha1h_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sha1h_pkg::queue_item_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_last_word
);
   import sha1h_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [60:0] count_ff, count_in;
   logic [6:0]  pos_ff, pos_in;
   logic [6:0]  round_ff, round_in;
   logic        pad_more_ff, pad_more_in;
   logic        final_ff, final_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   word_type    chain_ff [DigestWords];
   word_type    chain_in [DigestWords];
   word_type    win_ff [16];
   word_type    win_in [16];
   word_type    a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type    a_in, b_in, c_in, d_in, e_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        start_comp;
   logic [63:0] len_bits;
   logic [7:0]  pad_byte;
   word_type    round_f, round_k, round_t, sched_x;

   // padding byte: zeros, then the 64-bit message length, big-endian
   assign len_bits = {count_ff, 3'b000};
   assign pad_byte = (pad_more_ff || !(&pos_ff[5:3])) ? 8'h00
                   : len_bits[{~pos_ff[2:0], 3'b000} +: 8];

   // round function and constant by round group
   always_comb begin
      priority if (round_ff < 7'd20) begin
         round_f = (b_ff & c_ff) | (~b_ff & d_ff);
         round_k = K_ROUND0;
      end else if (round_ff < 7'd40) begin
         round_f = b_ff ^ c_ff ^ d_ff;
         round_k = K_ROUND1;
      end else if (round_ff < 7'd60) begin
         round_f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         round_k = K_ROUND2;
      end else begin
         round_f = b_ff ^ c_ff ^ d_ff;
         round_k = K_ROUND3;
      end
   end

   assign round_t = {a_ff[26:0], a_ff[31:27]} + round_f + e_ff + round_k + win_ff[0];
   assign sched_x = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      round_in     = round_ff;
      pad_more_in  = pad_more_ff;
      final_in     = final_ff;
      emit_idx_in  = emit_idx_ff;
      chain_in     = chain_ff;
      win_in       = win_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      start_comp   = 1'b0;

      // result register drains when taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.cmd)
                  CMD_ABSORB: begin
                     win_in[count_ff[5:2]][{~count_ff[1:0], 3'b000} +: 8] = head.data;
                     count_in = count_ff + 61'd1;
                     if (&count_ff[5:0]) begin
                        start_comp = 1'b1;
                     end
                  end
                  CMD_FINISH: begin
                     win_in[count_ff[5:2]][{~count_ff[1:0], 3'b000} +: 8] = PAD_MARKER;
                     pos_in      = {1'b0, count_ff[5:0]} + 7'd1;
                     pad_more_in = (count_ff[5:0] >= 6'd56);
                     state_in    = ST_PAD;
                  end
                  CMD_RESTART: begin
                     chain_in = INIT_VEC;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            if (pos_ff[6]) begin
               // first of two padding blocks is full
               start_comp = 1'b1;
            end else begin
               win_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = pad_byte;
               pos_in = pos_ff + 7'd1;
               if (!pad_more_ff && (&pos_ff[5:0])) begin
                  start_comp = 1'b1;
                  final_in   = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            a_in = round_t;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
            // sliding message schedule window
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = {sched_x[30:0], sched_x[31]};
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            priority if (final_ff) begin
               final_in    = 1'b0;
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end else if (pad_more_ff) begin
               pad_more_in = 1'b0;
               pos_in      = '0;
               state_in    = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[emit_idx_ff];
               rsp_index_in = emit_idx_ff;
               rsp_last_in  = (emit_idx_ff == LAST_WORD_INDEX);
               emit_idx_in  = emit_idx_ff + 3'd1;
               if (emit_idx_ff == LAST_WORD_INDEX) begin
                  chain_in = INIT_VEC;
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // load working variables at the start of a compression
      if (start_comp) begin
         state_in = ST_ROUND;
         round_in = '0;
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         round_ff     <= '0;
         pad_more_ff  <= 1'b0;
         final_ff     <= 1'b0;
         emit_idx_ff  <= '0;
         chain_ff     <= INIT_VEC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         pad_more_ff  <= pad_more_in;
         final_ff     <= final_in;
         emit_idx_ff  <= emit_idx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_last_word   = rsp_last_ff;

endmodule

>>> hdl/sha1h_checker.sv
module sha1h_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word) &&
                                 $stable(rsp_word_index) && $stable(rsp_last_word))
      else $error("stalled response changed");

   // last flag marks exactly the fifth word
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd4)))
      else $error("last flag does not match word index");

   // word index stays within the digest
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_index <= 3'd4))
      else $error("word index out of range");

   // after a word other than the last, the next one shown is its successor
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         !rsp_valid || (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of order");

   // reset drops any pending response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sha1_byte_stream_hasher_top sha1h_checker u_sha1h_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last_word   (rsp_last_word)
);

>>> tb/sv/tb_sha1_byte_stream_hasher_top.sv
module tb_sha1_byte_stream_hasher_top;
   import sha1h_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // command code 3 is accepted by the block and ignored
   localparam cmd_type CMD_UNUSED = 2'd3;

   // digest words of a finish arrive long after the request, so allow a wide tail
   localparam int TailCycles = 400;

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  data;
      int unsigned gap;
      bit          drain;
      bit          calm;
   } pending_req_type;

   typedef struct {
      word_type   word;
      logic [2:0] index;
      logic       last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cmd_type     req_cmd = CMD_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // predicted hash state
   word_type    hash_state [5];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_len;

   pending_req_type pending_reqs [$];
   digest_word_type digest_words_due [$];

   int unsigned mismatch_count = 0;
   int unsigned reqs_queued = 0;
   int unsigned reqs_taken = 0;
   int unsigned counted_reqs = 0;
   int unsigned finishes_taken = 0;
   int unsigned digest_words_seen = 0;
   int unsigned drain_pauses = 0;

   // handshake flags captured at the rising edge, used by the falling-edge drivers
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit quiet_mode = 1'b0;

   sha1_byte_stream_hasher_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic word_type rotl32(input word_type x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic restart_hash();
      for (int i = 0; i < 5; i++) hash_state[i] = INIT_VEC[i];
      msg_len = '0;
   endtask

   // 80-round compression of the current block into the hash state
   task automatic compress_block();
      word_type sched [80];
      word_type a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) begin
         sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end
      for (int i = 16; i < 80; i++) begin
         sched[i] = rotl32(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = rotl32(a, 5) + f + e + k + sched[i];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endtask

   // update the predicted state for one accepted request, queue any digest words
   task automatic predict_request(input cmd_type cmd, input logic [7:0] data);
      int unsigned pos;
      logic [63:0] bit_len;
      digest_word_type rec;
      pos = int'(msg_len[5:0]);
      case (cmd)
         CMD_ABSORB: begin
            msg_block[pos] = data;
            msg_len = msg_len + 61'd1;
            if (pos == 63) compress_block();
         end
         CMD_RESTART: begin
            restart_hash();
         end
         CMD_FINISH: begin
            msg_block[pos] = PAD_MARKER;
            pos++;
            // no room for the length field: pad out and compress an extra block
            if (pos > 56) begin
               while (pos < 64) begin
                  msg_block[pos] = 8'h00;
                  pos++;
               end
               compress_block();
               pos = 0;
            end
            while (pos < 56) begin
               msg_block[pos] = 8'h00;
               pos++;
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 5; i++) begin
               rec.word = hash_state[i];
               rec.index = 3'(i);
               rec.last = (i == 4);
               digest_words_due.push_back(rec);
            end
            restart_hash();
         end
         default: begin
            // unused command leaves the state alone
         end
      endcase
   endtask

   task automatic check_digest_word();
      digest_word_type due;
      if (digest_words_due.size() == 0) begin
         report_mismatch($sformatf("unexpected response word %h index %0d last %0b",
                                   rsp_digest_word, rsp_word_index, rsp_last_word));
      end else begin
         due = digest_words_due.pop_front();
         if (rsp_digest_word !== due.word)
            report_mismatch($sformatf("digest word %0d: got %h, want %h",
                                      due.index, rsp_digest_word, due.word));
         if (rsp_word_index !== due.index)
            report_mismatch($sformatf("word index: got %0d, want %0d",
                                      rsp_word_index, due.index));
         if (rsp_last_word !== due.last)
            report_mismatch($sformatf("last word flag at index %0d: got %0b, want %0b",
                                      due.index, rsp_last_word, due.last));
      end
   endtask

   task automatic add_request(input cmd_type cmd, input logic [7:0] data,
                              input bit drain, input bit calm);
      pending_req_type r;
      r.cmd = cmd;
      r.data = data;
      r.gap = calm ? 0 : $urandom_range(0, 5);
      r.drain = drain;
      r.calm = calm;
      pending_reqs.push_back(r);
      reqs_queued++;
      if (cmd != CMD_UNUSED) counted_reqs++;
   endtask

   // one message of len bytes with some noise, closed by a finish
   task automatic add_message(input int len, input bit calm, input bit drain_end);
      for (int i = 0; i < len; i++) begin
         if (!calm && $urandom_range(0, 9) == 0)
            add_request(CMD_UNUSED, 8'($urandom), 1'b0, calm);
         // broken message: drop what was absorbed so far
         if ($urandom_range(0, 59) == 0)
            add_request(CMD_RESTART, 8'($urandom), 1'b0, calm);
         add_request(CMD_ABSORB, 8'($urandom), 1'b0, calm);
      end
      add_request(CMD_FINISH, 8'($urandom), drain_end, calm);
   endtask

   // request driver
   always @(negedge clock) begin
      bit launch;
      bit gap_loaded;
      int unsigned gap_cnt;
      pending_req_type head;
      if (reset) begin
         req_valid <= 1'b0;
         gap_loaded = 1'b0;
         gap_cnt = 0;
      end else if (!req_valid || req_taken) begin
         launch = 1'b0;
         if (pending_reqs.size() != 0) begin
            if (!gap_loaded) begin
               gap_cnt = pending_reqs[0].gap;
               gap_loaded = 1'b1;
               if (pending_reqs[0].drain) drain_pauses++;
            end
            if (gap_cnt != 0) gap_cnt--;
            else if (pending_reqs[0].drain && digest_words_due.size() != 0) launch = 1'b0;
            else launch = 1'b1;
         end
         if (launch) begin
            head = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= head.cmd;
            req_data_byte <= head.data;
            quiet_mode <= head.calm;
            gap_loaded = 1'b0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(negedge clock) begin
      int unsigned stall_cnt;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_taken) stall_cnt = quiet_mode ? 0 : $urandom_range(0, 5);
         if (stall_cnt != 0) begin
            stall_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            reqs_taken++;
            if (req_cmd == CMD_FINISH) finishes_taken++;
            predict_request(req_cmd, req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            digest_words_seen++;
            check_digest_word();
         end
      end
   end

   // stimulus and end of run
   initial begin
      int len;
      bit calm;
      restart_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;

      // directed: empty message, byte extremes, the classic three-byte message
      add_request(CMD_FINISH, 8'hff, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h00, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h00, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'hff, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h5a, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h61, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h62, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h63, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h00, 1'b0, 1'b0);
      // restart mid-message, unused command with data, then finish of what remains
      add_request(CMD_ABSORB, 8'haa, 1'b0, 1'b0);
      add_request(CMD_RESTART, 8'hff, 1'b0, 1'b0);
      add_request(CMD_UNUSED, 8'hff, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h00, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h55, 1'b0, 1'b0);
      add_request(CMD_UNUSED, 8'h00, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h80, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h01, 1'b1, 1'b0);
      // restart right after finish has no visible effect
      add_request(CMD_RESTART, 8'h00, 1'b0, 1'b0);
      add_request(CMD_ABSORB, 8'h7f, 1'b0, 1'b0);
      add_request(CMD_FINISH, 8'h00, 1'b0, 1'b0);

      // padding boundaries: one block, length field spilling, exact block
      add_message(55, 1'b0, 1'b0);
      add_message(56, 1'b1, 1'b1);
      add_message(64, 1'b0, 1'b0);

      // random messages, mostly short
      while (counted_reqs < 215) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 15);
         calm = ($urandom_range(0, 3) == 0);
         add_message(len, calm, $urandom_range(0, 9) == 0);
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (reqs_taken != reqs_queued) @(negedge clock);
      while (digest_words_due.size() != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);

      if (digest_words_due.size() != 0)
         report_mismatch($sformatf("%0d digest words never arrived", digest_words_due.size()));
      $display("covered %0d requests with %0d finishes, %0d digest words checked,",
               reqs_taken, finishes_taken, digest_words_seen);
      $display("padding boundaries, restarts, unused commands and %0d drain pauses",
               drain_pauses);
      if (mismatch_count == 0) begin
         $display("** sha1_byte_stream_hasher_top: PASSED **");
      end else begin
         $display("** sha1_byte_stream_hasher_top: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("timeout: %0d of %0d requests taken, %0d digest words due",
               reqs_taken, reqs_queued, digest_words_due.size());
      $display("** sha1_byte_stream_hasher_top: FAILED **");
      $finish;
   end

endmodule
